// ----- hw/rtl/bcae_pkg.sv -----
package bcae_pkg;
  localparam int FRAME_W        = 20;
  localparam int SPAN_W         = 21;
  localparam int PT_W           = 16;
  localparam int SQ_W           = 2 * SPAN_W;
  localparam int CU_W           = 3 * SPAN_W;
  localparam int PT3_W          = PT_W + 2;
  localparam int PROD_W         = CU_W + 1 + PT3_W;
  localparam int WIDE_W         = PROD_W + 2;
  localparam int QUO_W          = 16;
  localparam int FRAME_BITS_DEF = 20;
endpackage

// ----- hw/rtl/cubic_bezier_axis_eval_top.sv -----
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready  | frame, span, axis, x0..y3
// out     | output    | out_valid / out_ready| curve_value
//
// One beat per cycle while the output is not held. The depth is set by the 16-step
// restoring divider, seven stages of multiply and sum, and the output register.
// Reset (rst_n low, synchronous) clears all valid bits.
// Every stage advances together; when the output beat is held, the whole
// pipe holds and in_ready drops.
module cubic_bezier_axis_eval_top
  import bcae_pkg::*;
#(
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [FRAME_W-1:0]      in_local_frame,
  input  logic [SPAN_W-1:0]       in_span_length,
  input  logic                    in_axis,
  input  logic signed [PT_W-1:0]  in_x0,
  input  logic signed [PT_W-1:0]  in_y0,
  input  logic signed [PT_W-1:0]  in_x1,
  input  logic signed [PT_W-1:0]  in_y1,
  input  logic signed [PT_W-1:0]  in_x2,
  input  logic signed [PT_W-1:0]  in_y2,
  input  logic signed [PT_W-1:0]  in_x3,
  input  logic signed [PT_W-1:0]  in_y3,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [PT_W-1:0]  out_curve_value
);
  logic                   en;
  logic                   c_vld, c_one;
  logic [CU_W-1:0]        c0, c1, c2, c3, cd;
  logic signed [PT_W-1:0] cp0, cp1, cp2, cp3;
  logic                   w_vld, w_one, w_neg;
  logic [WIDE_W-1:0]      w_num, w_den;
  logic signed [PT_W-1:0] w_p0;
  logic                   d_vld, d_one, d_neg;
  logic [QUO_W-1:0]       d_quo;
  logic signed [PT_W-1:0] d_p0;
  logic                   out_valid_r;
  logic signed [PT_W-1:0] out_value_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  bcae_coef #(.FRAME_BITS(FRAME_BITS)) u_coef (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(in_valid && en),
    .frame_i(in_local_frame), .span_i(in_span_length),
    .p0_i(in_axis ? in_y0 : in_x0), .p1_i(in_axis ? in_y1 : in_x1),
    .p2_i(in_axis ? in_y2 : in_x2), .p3_i(in_axis ? in_y3 : in_x3),
    .vld_o(c_vld), .one_o(c_one),
    .c0_o(c0), .c1_o(c1), .c2_o(c2), .c3_o(c3), .d_o(cd),
    .p0_o(cp0), .p1_o(cp1), .p2_o(cp2), .p3_o(cp3)
  );

  bcae_wsum u_wsum (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(c_vld), .one_i(c_one),
    .c0_i(c0), .c1_i(c1), .c2_i(c2), .c3_i(c3), .d_i(cd),
    .p0_i(cp0), .p1_i(cp1), .p2_i(cp2), .p3_i(cp3),
    .vld_o(w_vld), .one_o(w_one), .neg_o(w_neg),
    .num_o(w_num), .den_o(w_den), .p0_o(w_p0)
  );

  bcae_div u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(w_vld), .one_i(w_one), .neg_i(w_neg),
    .num_i(w_num), .den_i(w_den), .p0_i(w_p0),
    .vld_o(d_vld), .one_o(d_one), .neg_o(d_neg),
    .quo_o(d_quo), .p0_o(d_p0)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // zero or single-frame span bypasses the divider
      if (d_one) begin
        out_value_r <= d_p0;
      end else if (d_neg) begin
        out_value_r <= $signed(PT_W'(-d_quo));
      end else begin
        out_value_r <= $signed(PT_W'(d_quo));
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_curve_value = out_value_r;
endmodule

// ----- hw/rtl/bcae_coef.sv -----
module bcae_coef
  import bcae_pkg::*;
#(
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     vld_i,
  input  logic [FRAME_W-1:0]       frame_i,
  input  logic [SPAN_W-1:0]        span_i,
  input  logic signed [PT_W-1:0]   p0_i,
  input  logic signed [PT_W-1:0]   p1_i,
  input  logic signed [PT_W-1:0]   p2_i,
  input  logic signed [PT_W-1:0]   p3_i,
  output logic                     vld_o,
  output logic                     one_o,
  output logic [CU_W-1:0]          c0_o,
  output logic [CU_W-1:0]          c1_o,
  output logic [CU_W-1:0]          c2_o,
  output logic [CU_W-1:0]          c3_o,
  output logic [CU_W-1:0]          d_o,
  output logic signed [PT_W-1:0]   p0_o,
  output logic signed [PT_W-1:0]   p1_o,
  output logic signed [PT_W-1:0]   p2_o,
  output logic signed [PT_W-1:0]   p3_o
);
  localparam logic [SPAN_W:0] CAP = (SPAN_W+1)'(1) << FRAME_BITS;

  logic [SPAN_W:0]   span_sat;
  logic [SPAN_W-1:0] n_nxt, u_nxt, frame_ext;

  logic [2:0]                 vld_r;
  logic [2:0]                 one_r;
  logic [SPAN_W-1:0]          n1_r, u1_r, v1_r, n2_r, u2_r, v2_r;
  logic [SQ_W-1:0]            vv_r, uu_r, nn_r;
  logic signed [PT_W-1:0]     pa_r [3][4];
  logic [CU_W-1:0]            c0_r, c1_r, c2_r, c3_r, d_r;

  always_comb begin
    span_sat  = ({1'b0, span_i} > CAP) ? CAP : {1'b0, span_i};
    n_nxt     = (span_sat <= (SPAN_W+1)'(1)) ? '0 : SPAN_W'(span_sat - (SPAN_W+1)'(1));
    frame_ext = SPAN_W'(frame_i);
    u_nxt     = (frame_ext > n_nxt) ? n_nxt : frame_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      one_r    <= {one_r[1:0], (span_sat <= (SPAN_W+1)'(1))};
      n1_r     <= n_nxt;
      u1_r     <= u_nxt;
      v1_r     <= n_nxt - u_nxt;
      pa_r[0]  <= '{p0_i, p1_i, p2_i, p3_i};
      vv_r     <= SQ_W'(v1_r * v1_r);
      uu_r     <= SQ_W'(u1_r * u1_r);
      nn_r     <= SQ_W'(n1_r * n1_r);
      n2_r     <= n1_r;
      u2_r     <= u1_r;
      v2_r     <= v1_r;
      pa_r[1]  <= pa_r[0];
      c0_r     <= CU_W'(vv_r * v2_r);
      c1_r     <= CU_W'(vv_r * u2_r);
      c2_r     <= CU_W'(uu_r * v2_r);
      c3_r     <= CU_W'(uu_r * u2_r);
      d_r      <= CU_W'(nn_r * n2_r);
      pa_r[2]  <= pa_r[1];
    end
  end

  assign vld_o = vld_r[2];
  assign one_o = one_r[2];
  assign c0_o  = c0_r;
  assign c1_o  = c1_r;
  assign c2_o  = c2_r;
  assign c3_o  = c3_r;
  assign d_o   = d_r;
  assign p0_o  = pa_r[2][0];
  assign p1_o  = pa_r[2][1];
  assign p2_o  = pa_r[2][2];
  assign p3_o  = pa_r[2][3];
endmodule

// ----- hw/rtl/bcae_wsum.sv -----
module bcae_wsum
  import bcae_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    vld_i,
  input  logic                    one_i,
  input  logic [CU_W-1:0]         c0_i,
  input  logic [CU_W-1:0]         c1_i,
  input  logic [CU_W-1:0]         c2_i,
  input  logic [CU_W-1:0]         c3_i,
  input  logic [CU_W-1:0]         d_i,
  input  logic signed [PT_W-1:0]  p0_i,
  input  logic signed [PT_W-1:0]  p1_i,
  input  logic signed [PT_W-1:0]  p2_i,
  input  logic signed [PT_W-1:0]  p3_i,
  output logic                    vld_o,
  output logic                    one_o,
  output logic                    neg_o,
  output logic [WIDE_W-1:0]       num_o,
  output logic [WIDE_W-1:0]       den_o,
  output logic signed [PT_W-1:0]  p0_o
);
  logic signed [PT3_W-1:0]  q0, q1, q2, q3;
  logic signed [CU_W:0]     sc0, sc1, sc2, sc3;
  logic signed [PROD_W-1:0] t0_nxt, t1_nxt, t2_nxt, t3_nxt;
  logic signed [WIDE_W-1:0] sum_nxt;

  logic [3:0]               vld_r, one_r;
  logic signed [PROD_W-1:0] t0_r, t1_r, t2_r, t3_r;
  logic signed [WIDE_W-1:0] s01_r, s23_r, sum_r;
  logic [CU_W-1:0]          d_r [3];
  logic signed [PT_W-1:0]   p0_r [4];
  logic                     neg_r;
  logic [WIDE_W-1:0]        num_r, den_r;

  always_comb begin
    // middle weights carry the factor 3, folded into the points
    q0      = PT3_W'(p0_i);
    q1      = PT3_W'(p1_i) + (PT3_W'(p1_i) <<< 1);
    q2      = PT3_W'(p2_i) + (PT3_W'(p2_i) <<< 1);
    q3      = PT3_W'(p3_i);
    sc0     = $signed({1'b0, c0_i});
    sc1     = $signed({1'b0, c1_i});
    sc2     = $signed({1'b0, c2_i});
    sc3     = $signed({1'b0, c3_i});
    t0_nxt  = sc0 * q0;
    t1_nxt  = sc1 * q1;
    t2_nxt  = sc2 * q2;
    t3_nxt  = sc3 * q3;
    sum_nxt = s01_r + s23_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      one_r <= {one_r[2:0], one_i};
      t0_r  <= t0_nxt;
      t1_r  <= t1_nxt;
      t2_r  <= t2_nxt;
      t3_r  <= t3_nxt;
      d_r[0] <= d_i;
      p0_r[0] <= p0_i;
      s01_r <= WIDE_W'(t0_r) + WIDE_W'(t1_r);
      s23_r <= WIDE_W'(t2_r) + WIDE_W'(t3_r);
      d_r[1] <= d_r[0];
      p0_r[1] <= p0_r[0];
      sum_r <= sum_nxt;
      d_r[2] <= d_r[1];
      p0_r[2] <= p0_r[1];
      // round half away: floor((2|S| + d) / 2d)
      neg_r <= sum_r[WIDE_W-1];
      num_r <= ((sum_r[WIDE_W-1] ? WIDE_W'(-sum_r) : WIDE_W'(sum_r)) << 1)
               + WIDE_W'(d_r[2]);
      den_r <= WIDE_W'(d_r[2]) << 1;
      p0_r[3] <= p0_r[2];
    end
  end

  assign vld_o = vld_r[3];
  assign one_o = one_r[3];
  assign neg_o = neg_r;
  assign num_o = num_r;
  assign den_o = den_r;
  assign p0_o  = p0_r[3];
endmodule

// ----- hw/rtl/bcae_div.sv -----
module bcae_div
  import bcae_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    vld_i,
  input  logic                    one_i,
  input  logic                    neg_i,
  input  logic [WIDE_W-1:0]       num_i,
  input  logic [WIDE_W-1:0]       den_i,
  input  logic signed [PT_W-1:0]  p0_i,
  output logic                    vld_o,
  output logic                    one_o,
  output logic                    neg_o,
  output logic [QUO_W-1:0]        quo_o,
  output logic signed [PT_W-1:0]  p0_o
);
  logic                   vld_r [QUO_W];
  logic                   one_r [QUO_W];
  logic                   neg_r [QUO_W];
  logic [WIDE_W-1:0]      rem_r [QUO_W];
  logic [WIDE_W-1:0]      den_r [QUO_W];
  logic [QUO_W-1:0]       quo_r [QUO_W];
  logic signed [PT_W-1:0] p0_r  [QUO_W];

  // one quotient bit per stage, msb first
  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    localparam int B = QUO_W - 1 - k;
    logic                   vld_s, one_s, neg_s;
    logic [WIDE_W-1:0]      rem_s, den_s;
    logic [QUO_W-1:0]       quo_s;
    logic signed [PT_W-1:0] p0_s;
    logic [WIDE_W-1:0]      trial;
    logic                   take;

    if (k == 0) begin : g_head
      assign vld_s = vld_i;
      assign one_s = one_i;
      assign neg_s = neg_i;
      assign rem_s = num_i;
      assign den_s = den_i;
      assign quo_s = '0;
      assign p0_s  = p0_i;
    end else begin : g_body
      assign vld_s = vld_r[k-1];
      assign one_s = one_r[k-1];
      assign neg_s = neg_r[k-1];
      assign rem_s = rem_r[k-1];
      assign den_s = den_r[k-1];
      assign quo_s = quo_r[k-1];
      assign p0_s  = p0_r[k-1];
    end

    always_comb begin
      trial = den_s << B;
      take  = (rem_s >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_s;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        one_r[k] <= one_s;
        neg_r[k] <= neg_s;
        den_r[k] <= den_s;
        p0_r[k]  <= p0_s;
        rem_r[k] <= take ? rem_s - trial : rem_s;
        quo_r[k] <= quo_s | (take ? (QUO_W'(1) << B) : '0);
      end
    end
  end

  assign vld_o = vld_r[QUO_W-1];
  assign one_o = one_r[QUO_W-1];
  assign neg_o = neg_r[QUO_W-1];
  assign quo_o = quo_r[QUO_W-1];
  assign p0_o  = p0_r[QUO_W-1];
endmodule

// ----- test/tb.sv -----
module tb;
  import bcae_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [FRAME_W-1:0] in_local_frame = '0;
  logic [SPAN_W-1:0] in_span_length = '0;
  logic in_axis = 1'b0;
  logic signed [PT_W-1:0] in_x0 = '0, in_y0 = '0, in_x1 = '0, in_y1 = '0;
  logic signed [PT_W-1:0] in_x2 = '0, in_y2 = '0, in_x3 = '0, in_y3 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [PT_W-1:0] out_curve_value;

  localparam int LATENCY = 24;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [SPAN_W-1:0] span;
    logic axis;
    logic signed [PT_W-1:0] x0, y0, x1, y1, x2, y2, x3, y3;
  } curve_pt_t;

  typedef struct {
    curve_pt_t pt;
    bit known;
    logic signed [PT_W-1:0] value;
  } dir_row_t;

  cubic_bezier_axis_eval_top uut (.*);

  always #1 clk = ~clk;

  logic signed [PT_W-1:0] curve_q[$];
  int errors = 0;
  int n_in = 0;
  int n_out = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_stall = 0;
  bit long_hold = 0;

  // exact Bernstein evaluation, rounded half away from zero
  function automatic logic signed [PT_W-1:0] bezier_value(curve_pt_t p);
    logic [SPAN_W-1:0] span;
    logic [127:0] n, u, v, d, w0, w1, w2, w3, mag, q, rem;
    logic signed [127:0] s;
    logic signed [PT_W-1:0] p0, p1, p2, p3;
    p0 = p.axis ? p.y0 : p.x0;
    p1 = p.axis ? p.y1 : p.x1;
    p2 = p.axis ? p.y2 : p.x2;
    p3 = p.axis ? p.y3 : p.x3;
    span = p.span;
    if (span > (1 << 20)) span = SPAN_W'(1 << 20);
    if (span <= 1) return p0;
    n = 128'(span) - 128'(1);
    u = (128'(p.frame) > n) ? n : 128'(p.frame);
    v = n - u;
    d = n * n * n;
    w0 = v * v * v;
    w1 = 3 * v * v * u;
    w2 = 3 * v * u * u;
    w3 = u * u * u;
    s = $signed(w0) * p0 + $signed(w1) * p1 + $signed(w2) * p2 + $signed(w3) * p3;
    mag = (s < 0) ? -s : s;
    q = mag / d;
    rem = mag - q * d;
    if (2 * rem >= d) q = q + 1;
    return (s < 0) ? -q[PT_W-1:0] : q[PT_W-1:0];
  endfunction

  function automatic curve_pt_t rand_pt(bit wide);
    curve_pt_t p;
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    p = raw[$bits(curve_pt_t)-1:0];
    case ($urandom_range(0, 5))
      0: p.span = SPAN_W'($urandom_range(0, 3));
      1: p.span = SPAN_W'($urandom_range(1, 64));
      2: p.span = SPAN_W'((1 << 20) + $urandom_range(0, 1048575));
      3: p.span = SPAN_W'($urandom_range(1048500, 1048576));
      default: p.span = wide ? p.span : SPAN_W'($urandom_range(1, 4096));
    endcase
    if ($urandom_range(0, 3) != 0 && p.span > 1)
      p.frame = FRAME_W'($urandom_range(0, (p.span > 1048576 ? 1048576 : p.span) - 1));
    if ($urandom_range(0, 9) == 0) begin
      p.x1 = -p.x0; p.x2 = -p.x3; p.y1 = -p.y0; p.y2 = -p.y3;
    end
    return p;
  endfunction

  // valid stays up after an accepted beat until the next one or a drain drops it
  task automatic send_beat(curve_pt_t p);
    while (!long_hold && send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_local_frame, in_span_length, in_axis, in_x0, in_y0, in_x1, in_y1,
     in_x2, in_y2, in_x3, in_y3} <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_in++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (long_hold) @(posedge clk);
    while (curve_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("Some tests failed");
      $finish;
    end
  end

  // predictions are pushed on acceptance, before the pipe could return them
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      curve_q.push_back(bezier_value({in_local_frame, in_span_length, in_axis, in_x0,
                                      in_y0, in_x1, in_y1, in_x2, in_y2, in_x3, in_y3}));
    if (rst_n && out_valid && out_ready) begin
      n_out <= n_out + 1;
      if (curve_q.size() == 0) begin
        $display("%0t: unexpected beat, actual %0d", $time, out_curve_value);
        errors++;
      end else begin
        if (out_curve_value !== curve_q[0]) begin
          $display("%0t: curve_value expected %0d actual %0d", $time, curve_q[0],
                   out_curve_value);
          errors++;
        end
        void'(curve_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (long_hold) out_ready <= 1'b0;
    else out_ready <= !(recv_stall > 0 && $urandom_range(0, 99) < recv_stall);
  end

  dir_row_t dir_rows[$];

  function automatic curve_pt_t mk(int fr, int sp, bit ax, int a0, int a1, int a2, int a3);
    curve_pt_t p;
    p = '0;
    p.frame = FRAME_W'(fr); p.span = SPAN_W'(sp); p.axis = ax;
    if (ax) begin
      p.y0 = PT_W'(a0); p.y1 = PT_W'(a1); p.y2 = PT_W'(a2); p.y3 = PT_W'(a3);
      p.x0 = 16'h1234;
    end else begin
      p.x0 = PT_W'(a0); p.x1 = PT_W'(a1); p.x2 = PT_W'(a2); p.x3 = PT_W'(a3);
      p.y0 = 16'h4321;
    end
    return p;
  endfunction

  task automatic add_row(curve_pt_t p, bit known, int value);
    dir_row_t r;
    r.pt = p; r.known = known; r.value = PT_W'(value);
    dir_rows.push_back(r);
  endtask

  initial begin
    int held;
    dir_row_t r;
    add_row(mk(0, 1, 0, 32767, 1, 2, 3), 1, 32767);         // single-frame span
    add_row(mk(5, 0, 1, -32768, 1, 2, 3), 1, -32768);       // zero span
    add_row(mk(0, 10, 0, -32768, 0, 0, 32767), 1, -32768);  // start point
    add_row(mk(9, 10, 1, -32768, 0, 0, 32767), 1, 32767);   // end point
    add_row(mk(1048575, 10, 0, 5, 6, 7, 1000), 1, 1000);    // frame past span
    add_row(mk(1048575, 2097151, 0, 1, 2, 3, -77), 1, -77); // oversized span
    add_row(mk(2, 5, 0, 100, -100, 100, -100), 1, 0);       // zero sum
    add_row(mk(3, 7, 1, 32767, 32767, 32767, 32767), 1, 32767);
    add_row(mk(3, 7, 0, -32768, -32768, -32768, -32768), 1, -32768);
    add_row(mk(1, 3, 0, 0, 1, 0, 0), 0, 0);                 // rounding below a half
    add_row(mk(1, 3, 1, 0, -1, 0, 0), 0, 0);
    add_row(mk(524288, 1048576, 0, -32768, 32767, -32768, 32767), 0, 0);
    add_row(mk(1, 1048576, 1, 32767, -32768, 32767, -32768), 0, 0);
    add_row(mk(1048574, 1048576, 0, 1, 2, 3, 4), 0, 0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.known && bezier_value(r.pt) !== r.value) begin
        $display("%0t: table row %0d expected %0d actual %0d", $time, i, r.value,
                 bezier_value(r.pt));
        errors++;
      end
      send_beat(r.pt);
    end
    drain();  // sender pauses until all results are in

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 45; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 45; end
        default: begin send_idle = 13; recv_stall = 13; end
      endcase
      for (int k = 0; k < 150; k++) begin
        if (ph == 2 && k == 20) begin
          long_hold = 1;
          fork
            begin
              held = 0;
              while (held < 80) begin @(posedge clk); held++; end
              long_hold = 0;
            end
          join_none
        end
        send_beat(rand_pt(ph[0]));
      end
      drain();
    end

    $display("Sent %0d beats, got %0d results over four idle/stall mixes,", n_in, n_out);
    $display("with span and frame saturation, unit spans and a long output hold.");
    if (errors == 0 && curve_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
